[hw/rtl/dcqp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcqp_pkg
// Shared types and constants for the doorbell credit queue picker.
// ----------------------------------------------------------------------------
package dcqp_pkg;

   localparam int QueueIdW  = 6;
   localparam int PacketW   = 16;
   localparam int ReadW     = 6;
   localparam int MaskW     = 64;
   localparam int CountW    = 32;

   typedef enum logic [1:0] {
      MODE_DOORBELL = 2'd0,
      MODE_SELECT   = 2'd1,
      MODE_CONSUME  = 2'd2,
      MODE_UNUSED   = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   // write port of the credit store
   typedef struct packed {
      logic                en;
      logic [QueueIdW-1:0] addr;
      logic [CountW-1:0]   data;
   } store_write_type;

   // clamp a 33-bit signed result to the 32-bit signed range
   function automatic logic [CountW-1:0] sat_count(input logic [CountW:0] sum);
      logic [CountW-1:0] res;
      if (sum[CountW] != sum[CountW-1]) begin
         res = sum[CountW] ? {1'b1, {(CountW-1){1'b0}}} : {1'b0, {(CountW-1){1'b1}}};
      end else begin
         res = sum[CountW-1:0];
      end
      return res;
   endfunction

endpackage

[hw/rtl/dcqp_credit_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcqp_credit_store
// Per-queue credit count memory, registered synchronous read. Valid bits
// cleared at reset make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module dcqp_credit_store #(
   parameter int QUEUES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcqp_pkg::store_write_type     wr,
   input  logic                          rd_en,
   input  logic [dcqp_pkg::QueueIdW-1:0] rd_addr,
   output logic [dcqp_pkg::CountW-1:0]   rd_data
);
   import dcqp_pkg::*;

   localparam int AddrW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   logic [CountW-1:0] mem [QUEUES];
   logic [QUEUES-1:0] valid_ff;
   logic [QUEUES-1:0] valid_in;
   logic [CountW-1:0] rdata_ff;
   logic              rvalid_ff;

   logic [AddrW-1:0]  waddr;
   logic [AddrW-1:0]  raddr;

   assign waddr = wr.addr[AddrW-1:0];
   assign raddr = rd_addr[AddrW-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            rvalid_ff <= valid_ff[raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[waddr] <= wr.data;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

[hw/rtl/doorbell_credit_queue_picker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doorbell_credit_queue_picker
// Doorbell-driven receive queue scheduler with per-queue credit counters.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per item: doorbell add, select or consume, with
//   the queue, packet and read counts and the pause mask. rsp_* returns
//   exactly one word per item: found flag, queue, its credit after the step
//   and the pending bitmap after the step.
//   For each item, the accept cycle issues the read of the
//   credit memory (for select, at the queue the priority encoder picks),
//   the next cycle does the saturating update, the write-back and loads the
//   result register. A new word is taken only after the update of the last
//   one has finished, as the credit memory read and its write-back come first.
//   A result waiting in the output register does not block the next accept;
//   if the receiver stalls, the following item holds in its update cycle
//   until the output register frees.
//   Reset clears the pending bitmap and the per-entry valid bits of the
//   credit memory at once, so all counts read as zero; no clearing pass.
// ----------------------------------------------------------------------------
module doorbell_credit_queue_picker #(
   parameter int QUEUES   = 64,
   parameter int MAX_READ = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic [dcqp_pkg::QueueIdW-1:0] req_queue_id,
   input  logic [dcqp_pkg::PacketW-1:0]  req_packet_count,
   input  logic [dcqp_pkg::ReadW-1:0]    req_read_count,
   input  logic [dcqp_pkg::MaskW-1:0]    req_pause_mask,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [dcqp_pkg::QueueIdW-1:0] rsp_chosen_queue,
   output logic signed [dcqp_pkg::CountW-1:0] rsp_queue_credit,
   output logic [dcqp_pkg::MaskW-1:0]    rsp_pending_bits
);
   import dcqp_pkg::*;

   localparam int          AddrW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam logic [8:0]  MaxRead9 = MAX_READ[8:0];

   state_type            state_ff, state_in;
   mode_type             mode_ff;
   logic [QueueIdW-1:0]  qid_ff;
   logic [PacketW-1:0]   pkt_ff;
   logic [ReadW-1:0]     rd_ff;
   logic                 found_ff;
   logic                 in_range_ff;
   logic [QUEUES-1:0]    map_ff, map_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff;
   logic [QueueIdW-1:0]  rsp_chosen_ff;
   logic [CountW-1:0]    rsp_credit_ff;
   logic [MaskW-1:0]     rsp_pend_ff;

   logic                 accept;
   logic                 finish;
   logic                 req_in_range;
   logic [QUEUES-1:0]    eligible;
   logic                 pick_found;
   logic [QueueIdW-1:0]  pick_queue;
   logic                 rd_en;
   logic [QueueIdW-1:0]  rd_addr;
   logic [CountW-1:0]    cur_count;
   logic [CountW-1:0]    new_count;
   logic [CountW-1:0]    credit;
   logic [8:0]           rd_ext;
   logic [8:0]           rd_clamp;
   logic [MaskW-1:0]     pend_wide;
   logic [AddrW-1:0]     qaddr;
   store_write_type      wr;

   assign req_in_range = ({1'b0, req_queue_id} < 7'(QUEUES));
   assign eligible     = map_ff & ~req_pause_mask[QUEUES-1:0];

   // lowest-numbered eligible queue wins
   always_comb begin
      pick_found = 1'b0;
      pick_queue = '0;
      for (int i = QUEUES - 1; i >= 0; i--) begin
         if (eligible[i]) begin
            pick_found = 1'b1;
            pick_queue = QueueIdW'(i);
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rd_en     = accept && ((mode_type'(req_mode) == MODE_SELECT) || req_in_range);
   assign rd_addr   = (mode_type'(req_mode) == MODE_SELECT) ? pick_queue : req_queue_id;

   dcqp_credit_store #(
      .QUEUES (QUEUES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (cur_count)
   );

   assign rd_ext   = {3'b000, rd_ff};
   assign rd_clamp = (rd_ext > MaxRead9) ? MaxRead9 : rd_ext;
   assign qaddr    = qid_ff[AddrW-1:0];

   // saturating update and result selection
   always_comb begin
      new_count = cur_count;
      credit    = '0;
      map_in    = map_ff;
      case (mode_ff)
         MODE_DOORBELL: begin
            new_count = sat_count({cur_count[CountW-1], cur_count}
                                  + {{(CountW-PacketW+1){1'b0}}, pkt_ff});
            if (in_range_ff) begin
               credit = new_count;
               if (!new_count[CountW-1] && (new_count != '0)) begin
                  map_in[qaddr] = 1'b1;
               end
            end
         end
         MODE_CONSUME: begin
            new_count = sat_count({cur_count[CountW-1], cur_count}
                                  - {{(CountW-8){1'b0}}, rd_clamp});
            if (in_range_ff) begin
               credit = new_count;
               if (new_count[CountW-1] || (new_count == '0)) begin
                  map_in[qaddr] = 1'b0;
               end
            end
         end
         MODE_SELECT: begin
            credit = found_ff ? cur_count : '0;
         end
         default: begin
            credit = in_range_ff ? cur_count : '0;
         end
      endcase
   end

   always_comb begin
      pend_wide               = '0;
      pend_wide[QUEUES-1:0]   = map_in;
   end

   // the update cycle waits while an earlier word still sits unread
   assign finish = (state_ff == ST_UPDATE) && !(rsp_valid_ff && !rsp_ready);

   always_comb begin
      wr.en   = finish && in_range_ff
                && ((mode_ff == MODE_DOORBELL) || (mode_ff == MODE_CONSUME));
      wr.addr = qid_ff;
      wr.data = new_count;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         map_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            map_ff <= map_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= mode_type'(req_mode);
         qid_ff      <= (mode_type'(req_mode) == MODE_SELECT) ? pick_queue : req_queue_id;
         pkt_ff      <= req_packet_count;
         rd_ff       <= req_read_count;
         found_ff    <= (mode_type'(req_mode) == MODE_SELECT) && pick_found;
         in_range_ff <= req_in_range;
      end
      if (finish) begin
         rsp_found_ff  <= found_ff;
         rsp_chosen_ff <= qid_ff;
         rsp_credit_ff <= credit;
         rsp_pend_ff   <= pend_wide;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_chosen_queue = rsp_chosen_ff;
   assign rsp_queue_credit = rsp_credit_ff;
   assign rsp_pending_bits = rsp_pend_ff;

endmodule

[bench/credit_check_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_check_pkg
// Tracks queue credits and the pending bitmap alongside the picker and
// checks each returned word against the word expected for it.
// ----------------------------------------------------------------------------
package credit_check_pkg;

   import dcqp_pkg::*;

   localparam int QUEUES   = 64;
   localparam int MAX_READ = 32;

   localparam longint CREDIT_HI = 64'sd2147483647;
   localparam longint CREDIT_LO = -64'sd2147483648;

   typedef struct {
      logic                     found;
      logic [QueueIdW-1:0]      queue;
      logic signed [CountW-1:0] credit;
      logic [MaskW-1:0]         bits;
   } picker_word_type;

   class queue_credit_tracker;
      int              credit [QUEUES];
      logic [63:0]     pending_map;
      picker_word_type expected_words [$];
      int              errors;

      function new();
         foreach (credit[i]) credit[i] = 0;
         pending_map = '0;
         errors      = 0;
      endfunction

      function int outstanding();
         return expected_words.size();
      endfunction

      function int clamp_credit(longint sum);
         if (sum > CREDIT_HI) return int'(CREDIT_HI);
         if (sum < CREDIT_LO) return int'(CREDIT_LO);
         return int'(sum);
      endfunction

      // work out the word the picker owes for one accepted request
      function void predict_word(logic [1:0] mode, logic [QueueIdW-1:0] q,
                                 logic [PacketW-1:0] pc, logic [ReadW-1:0] rc,
                                 logic [MaskW-1:0] mask);
         picker_word_type w;
         mode_type        m;
         longint          sum;
         int              rd;
         int              i;
         logic [63:0]     eligible;
         m        = mode_type'(mode);
         w.found  = 1'b0;
         w.queue  = q;
         w.credit = '0;
         if (m == MODE_SELECT) begin
            eligible = pending_map & ~mask &
                       ((QUEUES >= 64) ? {64{1'b1}} : ((64'd1 << QUEUES) - 64'd1));
            w.queue = '0;
            // scan downwards so the lowest eligible queue wins
            for (i = QUEUES - 1; i >= 0; i--) begin
               if (eligible[i]) begin
                  w.found  = 1'b1;
                  w.queue  = i[QueueIdW-1:0];
                  w.credit = credit[i];
               end
            end
         end else if (int'(q) < QUEUES) begin
            case (m)
               MODE_DOORBELL: begin
                  sum       = longint'(credit[q]) + longint'(pc);
                  credit[q] = clamp_credit(sum);
                  if (credit[q] > 0) pending_map[q] = 1'b1;
               end
               MODE_CONSUME: begin
                  rd        = (int'(rc) > MAX_READ) ? MAX_READ : int'(rc);
                  sum       = longint'(credit[q]) - longint'(rd);
                  credit[q] = clamp_credit(sum);
                  if (credit[q] <= 0) pending_map[q] = 1'b0;
               end
               default: begin
               end
            endcase
            w.credit = credit[q];
         end
         w.bits = pending_map;
         expected_words.push_back(w);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch on %s: got %h, expected %h", what, got, want);
      endtask

      task check_word(logic found, logic [QueueIdW-1:0] queue,
                      logic signed [CountW-1:0] credit_got, logic [MaskW-1:0] bits);
         picker_word_type w;
         if (expected_words.size() == 0) begin
            report_mismatch("word with nothing expected", 64'(queue), '0);
            return;
         end
         w = expected_words.pop_front();
         if (found !== w.found) report_mismatch("found", 64'(found), 64'(w.found));
         if (queue !== w.queue) report_mismatch("chosen_queue", 64'(queue), 64'(w.queue));
         if (credit_got !== w.credit)
            report_mismatch("queue_credit", 64'(credit_got), 64'(w.credit));
         if (bits !== w.bits) report_mismatch("pending_bits", bits, w.bits);
      endtask
   endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bench for the doorbell credit queue picker: directed corner words, a run
// of full doorbells on one queue, then random traffic with random stalls on
// both sides, a long receiver hold-off and a quiet tail.
// ----------------------------------------------------------------------------
module tb_top;

   import dcqp_pkg::*;
   import credit_check_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_mode = '0;
   logic [QueueIdW-1:0]      req_queue_id = '0;
   logic [PacketW-1:0]       req_packet_count = '0;
   logic [ReadW-1:0]         req_read_count = '0;
   logic [MaskW-1:0]         req_pause_mask = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_found;
   logic [QueueIdW-1:0]      rsp_chosen_queue;
   logic signed [CountW-1:0] rsp_queue_credit;
   logic [MaskW-1:0]         rsp_pending_bits;

   queue_credit_tracker tracker = new();

   bit quiet    = 1'b0;
   bit hold_rsp = 1'b0;
   int idle_cycles = 0;

   doorbell_credit_queue_picker #(
      .QUEUES   (QUEUES),
      .MAX_READ (MAX_READ)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_queue_id     (req_queue_id),
      .req_packet_count (req_packet_count),
      .req_read_count   (req_read_count),
      .req_pause_mask   (req_pause_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_chosen_queue (rsp_chosen_queue),
      .rsp_queue_credit (rsp_queue_credit),
      .rsp_pending_bits (rsp_pending_bits)
   );

   always #5 clock = ~clock;

   // offer one word, hold it until taken, then maybe leave a gap
   task automatic send_word(input logic [1:0] mode, input logic [QueueIdW-1:0] q,
                            input logic [PacketW-1:0] pc, input logic [ReadW-1:0] rc,
                            input logic [MaskW-1:0] mask);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_queue_id     <= q;
      req_packet_count <= pc;
      req_read_count   <= rc;
      req_pause_mask   <= mask;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.predict_word(mode, q, pc, rc, mask);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   function automatic logic [MaskW-1:0] pick_mask();
      logic [MaskW-1:0] sparse;
      sparse = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return {$urandom, $urandom};
         3: return sparse;
         4: return ~sparse;
         default: return 64'd1 << $urandom_range(0, 63);
      endcase
   endfunction

   task automatic send_random_word();
      mode_type            m;
      logic [QueueIdW-1:0] q;
      logic [PacketW-1:0]  pc;
      logic [ReadW-1:0]    rc;
      int                  pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      m = MODE_DOORBELL;
      else if (pick < 65) m = MODE_SELECT;
      else if (pick < 95) m = MODE_CONSUME;
      else                m = MODE_UNUSED;
      // a few busy queues at each end keep counts crossing zero
      pick = $urandom_range(0, 9);
      if (pick < 6)      q = QueueIdW'($urandom_range(0, 5));
      else if (pick < 8) q = QueueIdW'($urandom_range(58, 63));
      else               q = QueueIdW'($urandom_range(0, 63));
      pick = $urandom_range(0, 9);
      if (pick < 6)      pc = PacketW'($urandom_range(1, 40));
      else if (pick < 8) pc = '0;
      else               pc = PacketW'($urandom_range(0, 65535));
      rc = ($urandom_range(0, 4) != 0) ? ReadW'($urandom_range(0, 40))
                                       : ReadW'($urandom_range(0, 63));
      send_word(m, q, pc, rc, pick_mask());
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_word(rsp_found, rsp_chosen_queue, rsp_queue_credit, rsp_pending_bits);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // receiver: random ready bursts, one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty store: zero doorbell keeps the bit clear, select finds nothing
      send_word(MODE_DOORBELL, 6'd0, 16'd0, 6'd0, '0);
      send_word(MODE_SELECT, 6'd63, 16'hFFFF, 6'h3F, '0);
      send_word(MODE_DOORBELL, 6'd0, 16'hFFFF, 6'd0, '1);
      send_word(MODE_DOORBELL, 6'd63, 16'd1, 6'd0, '0);
      send_word(MODE_SELECT, 6'd0, 16'd0, 6'd0, '0);
      send_word(MODE_SELECT, 6'd0, 16'd0, 6'd0, 64'd1);
      send_word(MODE_SELECT, 6'd0, 16'd0, 6'd0, '1);
      send_word(MODE_UNUSED, 6'd0, 16'hFFFF, 6'h3F, '1);
      // excess read on queue 63 drives it negative and clears its bit
      send_word(MODE_CONSUME, 6'd63, 16'd0, 6'h3F, '0);
      send_word(MODE_DOORBELL, 6'd63, 16'd5, 6'd0, '0);
      send_word(MODE_SELECT, 6'd0, 16'd0, 6'd0, 64'd1);
      send_word(MODE_CONSUME, 6'd0, 16'd0, 6'd32, '0);
      send_word(MODE_CONSUME, 6'd0, 16'd0, 6'd0, '0);
      send_word(MODE_UNUSED, 6'd63, 16'd0, 6'd0, '0);
      send_word(MODE_DOORBELL, 6'd31, 16'h5555, 6'h15, 64'h5555_5555_5555_5555);
      send_word(MODE_DOORBELL, 6'd32, 16'hAAAA, 6'h2A, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(MODE_SELECT, 6'd21, 16'd0, 6'd0, 64'h0000_0000_FFFF_FFFF);
      send_word(MODE_SELECT, 6'd42, 16'd0, 6'd0, 64'hFFFF_FFFE_FFFF_FFFF);
      send_word(MODE_CONSUME, 6'd31, 16'd0, 6'd33, '0);
      send_word(MODE_CONSUME, 6'd0, 16'd0, 6'd31, '0);
      send_word(MODE_CONSUME, 6'd63, 16'd0, 6'd1, '0);

      // a run of full doorbells builds a large count on one queue
      for (int i = 0; i < 20; i++) send_word(MODE_DOORBELL, 6'd17, 16'hFFFF, 6'd0, '0);
      send_word(MODE_UNUSED, 6'd17, 16'd0, 6'd0, '0);
      send_word(MODE_CONSUME, 6'd17, 16'd0, 6'd32, '0);
      send_word(MODE_DOORBELL, 6'd17, 16'hFFFF, 6'd0, '0);
      send_word(MODE_SELECT, 6'd0, 16'd0, 6'd0, ~(64'd1 << 17));

      for (int i = 0; i < 260; i++) send_random_word();

      // receiver holds off while words keep coming, so the input stalls
      hold_rsp = 1'b1;
      for (int i = 0; i < 40; i++) send_random_word();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);

      for (int i = 0; i < 260; i++) send_random_word();
      quiet = 1'b1;
      for (int i = 0; i < 150; i++) send_random_word();

      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[doorbell_credit_queue_picker.f]
hw/rtl/dcqp_pkg.sv
hw/rtl/dcqp_credit_store.sv
hw/rtl/doorbell_credit_queue_picker.sv
bench/credit_check_pkg.sv
bench/tb_top.sv
